// ===== rtl/dld_pkg.sv =====
// shared types and constants of the decimal long divider
package dld_pkg;

  // result kinds
  localparam logic [1:0] KIND_QUOT  = 2'd0;
  localparam logic [1:0] KIND_DIGIT = 2'd1;
  localparam logic [1:0] KIND_ERR   = 2'd2;

  localparam int CFG_BITS = 4;
  localparam logic [CFG_BITS-1:0] FRACTION_DIGITS_RESET = 4'd3;

  // one decimal digit needs four quotient bits
  localparam int DIGIT_BITS = 4;

  localparam int QUEUE_DEPTH = 2;
  localparam int PTR_BITS    = $clog2(QUEUE_DEPTH);
  localparam int COUNT_BITS  = $clog2(QUEUE_DEPTH + 1);

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

endpackage

// ===== rtl/decimal_long_divider_top.sv =====
// decimal long divider: quotient then decimal fraction digits of each item
//
// input channel: in_valid, in_stall, dividend, divisor. an item is taken at a
//   clock edge with in_valid high and in_stall low.
// output channel: out_valid, out_stall, kind, value, last. kind 0 is the
//   integer quotient, 1 a fraction digit, 2 a divide-by-zero error (value 0).
//   last marks the final result of an item.
// config channel: cfg_valid, cfg_ready, fraction_digits; write only while idle.
//   0 acts as 1, values above MAX_FRACTION_DIGITS act as that maximum.
// structure: an input register and a two-item queue feed the divider, so up
//   to three items wait while one is worked on. the quotient is a restoring
//   divider taking one bit per cycle; each fraction digit takes four
//   compare-subtract steps and then an output step. one item occupies the
//   divider until its last result is out.
// reset: synchronous, clears queue and output, fraction_digits goes to 3.
// a stalled receiver holds the output register; the divider waits on it, the
//   queue and input register absorb items until full, then in_stall rises.
module decimal_long_divider_top #(
  parameter int MAX_FRACTION_DIGITS = 10,
  parameter int OPERAND_BITS        = 31
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [OPERAND_BITS-1:0]       dividend,
  input  logic [OPERAND_BITS-1:0]       divisor,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [1:0]                    kind,
  output logic [OPERAND_BITS-1:0]       value,
  output logic                          last,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [dld_pkg::CFG_BITS-1:0]  fraction_digits
);

  localparam int EW = 2 * OPERAND_BITS + 1;

  logic [dld_pkg::CFG_BITS-1:0] digit_cfg;
  dld_pkg::q_status_t           q_status;
  logic                         push;
  logic                         pop;
  logic [EW-1:0]                entry;
  logic [EW-1:0]                q_data;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      digit_cfg <= dld_pkg::FRACTION_DIGITS_RESET;
    end else if (cfg_valid && cfg_ready) begin
      digit_cfg <= fraction_digits;
    end
  end

  dld_front #(
    .OPERAND_BITS(OPERAND_BITS)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .dividend (dividend),
    .divisor  (divisor),
    .q_status (q_status),
    .push     (push),
    .entry    (entry)
  );

  dld_queue #(
    .WIDTH(EW)
  ) u_queue (
    .clk    (clk),
    .rst    (rst),
    .push   (push),
    .wdata  (entry),
    .pop    (pop),
    .rdata  (q_data),
    .status (q_status)
  );

  dld_back #(
    .MAX_FRACTION_DIGITS(MAX_FRACTION_DIGITS),
    .OPERAND_BITS       (OPERAND_BITS)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .q_status  (q_status),
    .q_data    (q_data),
    .pop       (pop),
    .digit_cfg (digit_cfg),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .kind      (kind),
    .value     (value),
    .last      (last)
  );

endmodule

// ===== rtl/dld_front.sv =====
// input stage: takes items and flags a zero divisor before queueing
module dld_front #(
  parameter int OPERAND_BITS = 31
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic [OPERAND_BITS-1:0]   dividend,
  input  logic [OPERAND_BITS-1:0]   divisor,
  input  dld_pkg::q_status_t        q_status,
  output logic                      push,
  output logic [2*OPERAND_BITS:0]   entry
);

  logic                    hold;
  logic                    zero;
  logic [OPERAND_BITS-1:0] dvd;
  logic [OPERAND_BITS-1:0] dvs;
  logic                    accept;

  assign in_stall = hold && q_status.full;
  assign accept   = in_valid && !in_stall;
  assign push     = hold && !q_status.full;
  assign entry    = {zero, dvd, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      hold <= 1'b0;
    end else begin
      hold <= accept || (hold && q_status.full);
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      dvd  <= dividend;
      dvs  <= divisor;
      zero <= (divisor == '0);
    end
  end

endmodule

// ===== rtl/dld_queue.sv =====
// short queue between the front and the divider
module dld_queue #(
  parameter int WIDTH = 63
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 push,
  input  logic [WIDTH-1:0]     wdata,
  input  logic                 pop,
  output logic [WIDTH-1:0]     rdata,
  output dld_pkg::q_status_t   status
);

  logic [WIDTH-1:0]               slots [dld_pkg::QUEUE_DEPTH];
  logic [dld_pkg::PTR_BITS-1:0]   wr_ptr;
  logic [dld_pkg::PTR_BITS-1:0]   rd_ptr;
  logic [dld_pkg::COUNT_BITS-1:0] count;
  logic                           do_push;
  logic                           do_pop;

  assign status.full  = (count == dld_pkg::COUNT_BITS'(dld_pkg::QUEUE_DEPTH));
  assign status.empty = (count == '0);
  assign do_push      = push && !status.full;
  assign do_pop       = pop && !status.empty;
  assign rdata        = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= wdata;
    end
  end

endmodule

// ===== rtl/dld_back.sv =====
// divider core: bit-serial quotient, then decimal digits, with output register
module dld_back #(
  parameter int MAX_FRACTION_DIGITS = 10,
  parameter int OPERAND_BITS        = 31
) (
  input  logic                              clk,
  input  logic                              rst,
  input  dld_pkg::q_status_t                q_status,
  input  logic [2*OPERAND_BITS:0]           q_data,
  output logic                              pop,
  input  logic [dld_pkg::CFG_BITS-1:0]      digit_cfg,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [1:0]                        kind,
  output logic [OPERAND_BITS-1:0]           value,
  output logic                              last
);

  localparam int N  = OPERAND_BITS;
  localparam int CW = $clog2(N);
  localparam int LW = $clog2(MAX_FRACTION_DIGITS + 1);
  localparam int TW = N + dld_pkg::DIGIT_BITS;

  typedef enum logic [2:0] {
    S_IDLE,
    S_ERR,
    S_DIV,
    S_QUO,
    S_DIG,
    S_DOUT
  } state_t;

  state_t                          state;
  logic [N-1:0]                    den;
  logic [N-1:0]                    quo;
  logic [N-1:0]                    rem;
  logic [CW-1:0]                   cnt;
  logic [TW-1:0]                   t;
  logic [1:0]                      step;
  logic [dld_pkg::DIGIT_BITS-1:0]  digit;
  logic [LW-1:0]                   dleft;

  logic                            q_zero;
  logic [N-1:0]                    q_dividend;
  logic [N-1:0]                    q_divisor;
  logic [N:0]                      shift_in;
  logic                            fits;
  logic [N:0]                      diff;
  logic [TW-1:0]                   den_sh;
  logic                            t_fits;
  logic                            out_free;
  logic                            emit;
  logic [LW-1:0]                   limit;
  logic                            dig_last;

  function automatic logic [TW-1:0] times10(input logic [N-1:0] x);
    times10 = (TW'(x) << 3) + (TW'(x) << 1);
  endfunction

  assign q_zero     = q_data[2*N];
  assign q_dividend = q_data[2*N-1:N];
  assign q_divisor  = q_data[N-1:0];

  assign pop      = (state == S_IDLE) && !q_status.empty;
  assign out_free = !out_valid || !out_stall;
  // output register takes a new item in the result states once it is free
  assign emit     = out_free && (state inside {S_ERR, S_QUO, S_DOUT});

  // one restoring step per cycle
  assign shift_in = {rem, quo[N-1]};
  assign fits     = (shift_in >= {1'b0, den});
  assign diff     = shift_in - {1'b0, den};

  // digit = floor(rem*10/den), four compare-subtract steps
  assign den_sh   = TW'(den) << step;
  assign t_fits   = (t >= den_sh);
  assign dig_last = (t == '0) || (dleft == LW'(1));

  always_comb begin
    if (digit_cfg == '0) begin
      limit = LW'(1);
    end else if (32'(digit_cfg) > 32'(MAX_FRACTION_DIGITS)) begin
      limit = LW'(MAX_FRACTION_DIGITS);
    end else begin
      limit = LW'(digit_cfg);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      if (emit) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (!q_status.empty) begin
            den   <= q_divisor;
            quo   <= q_dividend;
            rem   <= '0;
            cnt   <= CW'(N - 1);
            state <= q_zero ? S_ERR : S_DIV;
          end
        end
        S_ERR: begin
          if (out_free) begin
            kind      <= dld_pkg::KIND_ERR;
            value     <= '0;
            last      <= 1'b1;
            state     <= S_IDLE;
          end
        end
        S_DIV: begin
          rem <= fits ? diff[N-1:0] : shift_in[N-1:0];
          quo <= {quo[N-2:0], fits};
          if (cnt == '0) begin
            state <= S_QUO;
          end else begin
            cnt <= cnt - 1'b1;
          end
        end
        S_QUO: begin
          if (out_free) begin
            kind      <= dld_pkg::KIND_QUOT;
            value     <= quo;
            last      <= (rem == '0);
            dleft     <= limit;
            t         <= times10(rem);
            step      <= 2'd3;
            digit     <= '0;
            state     <= (rem == '0) ? S_IDLE : S_DIG;
          end
        end
        S_DIG: begin
          if (t_fits) begin
            t <= t - den_sh;
          end
          digit[step] <= t_fits;
          if (step == 2'd0) begin
            state <= S_DOUT;
          end else begin
            step <= step - 1'b1;
          end
        end
        S_DOUT: begin
          if (out_free) begin
            kind      <= dld_pkg::KIND_DIGIT;
            value     <= N'(digit);
            last      <= dig_last;
            if (dig_last) begin
              state <= S_IDLE;
            end else begin
              // t now holds the new remainder, below den
              dleft <= dleft - 1'b1;
              t     <= times10(t[N-1:0]);
              step  <= 2'd3;
              digit <= '0;
              state <= S_DIG;
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  a_digit_range: assert property (@(posedge clk) disable iff (rst)
    out_valid && kind == dld_pkg::KIND_DIGIT |-> value < N'(10))
    else $error("fraction digit above nine");

  a_err_shape: assert property (@(posedge clk) disable iff (rst)
    out_valid && kind == dld_pkg::KIND_ERR |-> value == '0 && last)
    else $error("error result not zero or not final");

  a_div_nonzero: assert property (@(posedge clk) disable iff (rst)
    state == S_DIV |-> den != '0)
    else $error("dividing by a zero divisor");

  a_pop_start: assert property (@(posedge clk) disable iff (rst)
    pop |=> state == S_DIV || state == S_ERR)
    else $error("popped item did not start");

endmodule

// ===== sim/tb_top.sv =====
// self-checking testbench for the decimal long divider top level
module tb_top;

  localparam int OPERAND_BITS = 31;
  localparam int MAX_DIGITS   = 10;
  localparam int DRAIN_CYCLES = 100;

  typedef logic [OPERAND_BITS-1:0] operand_t;

  typedef struct {
    logic [1:0] kind;
    operand_t   value;
    logic       last;
    int         item;
  } division_result_t;

  logic                         clk = 1'b0;
  logic                         rst = 1'b1;
  logic                         in_valid = 1'b0;
  logic                         in_stall;
  operand_t                     dividend = '0;
  operand_t                     divisor = '0;
  logic                         out_valid;
  logic                         out_stall = 1'b0;
  logic [1:0]                   kind;
  operand_t                     value;
  logic                         last;
  logic                         cfg_valid = 1'b0;
  logic                         cfg_ready;
  logic [dld_pkg::CFG_BITS-1:0] fraction_digits = '0;

  division_result_t expected_results[$];
  logic [dld_pkg::CFG_BITS-1:0] digit_setting = dld_pkg::FRACTION_DIGITS_RESET;
  int mismatch_count = 0;
  int items_sent = 0;

  // receiver stall pattern, changed by the tests
  int stall_max = 0;
  int stall_left = 0;
  int free_left = 0;

  decimal_long_divider_top #(
    .MAX_FRACTION_DIGITS(MAX_DIGITS),
    .OPERAND_BITS(OPERAND_BITS)
  ) uut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .dividend(dividend),
    .divisor(divisor),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .kind(kind),
    .value(value),
    .last(last),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .fraction_digits(fraction_digits)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  task automatic report_mismatch(input string msg);
    $display("mismatch at %0t: %s", $time, msg);
    mismatch_count++;
  endtask

  // quotient first, then digits until the remainder is gone or the limit is hit
  function automatic void predict_division(input operand_t num, input operand_t den,
                                           input int item);
    division_result_t r;
    longint unsigned rem;
    longint unsigned wide_den;
    int limit;
    int n;
    r.item = item;
    wide_den = den;
    if (den == '0) begin
      r.kind = dld_pkg::KIND_ERR;
      r.value = '0;
      r.last = 1'b1;
      expected_results.push_back(r);
      return;
    end
    rem = num % wide_den;
    r.kind = dld_pkg::KIND_QUOT;
    r.value = operand_t'(num / wide_den);
    r.last = (rem == 0);
    expected_results.push_back(r);
    if (digit_setting == 0) limit = 1;
    else if (digit_setting > MAX_DIGITS) limit = MAX_DIGITS;
    else limit = int'(digit_setting);
    for (n = 0; n < limit && rem != 0; n++) begin
      rem = rem * 10;
      r.kind = dld_pkg::KIND_DIGIT;
      r.value = operand_t'(rem / wide_den);
      rem = rem % wide_den;
      r.last = (rem == 0) || (n + 1 == limit);
      expected_results.push_back(r);
    end
  endfunction

  always @(posedge clk) begin
    division_result_t want;
    if (!rst && out_valid && !out_stall) begin
      if (expected_results.size() == 0) begin
        report_mismatch($sformatf("unexpected result kind %0d value %0d last %0d",
                                  kind, value, last));
      end else begin
        want = expected_results.pop_front();
        if (kind !== want.kind)
          report_mismatch($sformatf("item %0d kind %0d, want %0d", want.item, kind,
                                    want.kind));
        if (value !== want.value)
          report_mismatch($sformatf("item %0d value %0d, want %0d", want.item, value,
                                    want.value));
        if (last !== want.last)
          report_mismatch($sformatf("item %0d last %0d, want %0d", want.item, last,
                                    want.last));
      end
    end
  end

  always @(negedge clk) begin
    if (rst || stall_max == 0) begin
      out_stall <= 1'b0;
    end else if (stall_left > 0) begin
      out_stall <= 1'b1;
      stall_left--;
    end else if (free_left > 0) begin
      out_stall <= 1'b0;
      free_left--;
    end else begin
      out_stall <= 1'b1;
      stall_left = $urandom_range(0, stall_max - 1);
      free_left = $urandom_range(1, 6);
    end
  end

  task automatic send_item(input operand_t num, input operand_t den);
    @(negedge clk);
    in_valid <= 1'b1;
    dividend <= num;
    divisor <= den;
    do @(posedge clk); while (in_stall);
    predict_division(num, den, items_sent);
    items_sent++;
  endtask

  task automatic idle_cycles(input int n);
    if (n > 0) begin
      @(negedge clk);
      in_valid <= 1'b0;
      repeat (n - 1) @(negedge clk);
    end
  endtask

  // sender holds off until the block has delivered everything
  task automatic wait_results_done();
    @(negedge clk);
    in_valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_digit_setting(input logic [dld_pkg::CFG_BITS-1:0] setting);
    wait_results_done();
    @(negedge clk);
    cfg_valid <= 1'b1;
    fraction_digits <= setting;
    do @(posedge clk); while (!cfg_ready);
    digit_setting = setting;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  function automatic void pick_operands(output operand_t num, output operand_t den);
    int unsigned sel;
    int unsigned d;
    int unsigned terminating[13] = '{2, 4, 5, 8, 16, 20, 25, 32, 40, 50, 64, 80, 125};
    sel = $urandom_range(0, 99);
    if (sel < 5) begin
      num = operand_t'($urandom);
      den = '0;
    end else if (sel < 35) begin
      den = operand_t'($urandom_range(1, 30));
      num = operand_t'($urandom);
    end else if (sel < 65) begin
      // fraction only, so all the digits matter
      d = $urandom & 32'h7fff_ffff;
      if (d == 0) d = 1;
      den = operand_t'(d);
      num = operand_t'($urandom % d);
    end else if (sel < 82) begin
      num = operand_t'($urandom) >> $urandom_range(0, 30);
      den = operand_t'($urandom) >> $urandom_range(0, 30);
      if (den == '0) den = 1;
    end else if (sel < 90) begin
      d = $urandom_range(1, 5000);
      den = operand_t'(d);
      num = operand_t'(d * $urandom_range(0, 32'h7fff_ffff / d));
    end else begin
      den = operand_t'(terminating[$urandom_range(0, 12)]);
      num = operand_t'($urandom);
    end
  endfunction

  task automatic run_random_items(input int count, input int gap_max);
    int sent;
    int burst;
    int k;
    operand_t num;
    operand_t den;
    sent = 0;
    while (sent < count) begin
      burst = $urandom_range(1, 8);
      for (k = 0; k < burst && sent < count; k++) begin
        pick_operands(num, den);
        send_item(num, den);
        sent++;
      end
      if (gap_max > 0) idle_cycles($urandom_range(0, gap_max));
    end
  endtask

  // runs at the reset digit setting
  task automatic test_directed();
    localparam operand_t TOP = '1;
    stall_max = 0;
    send_item('0, 31'd1);
    send_item(TOP, 31'd1);
    send_item(TOP, TOP);
    send_item('0, TOP);
    send_item(31'd1, TOP);
    send_item(TOP - 1, TOP);
    send_item(TOP, '0);
    send_item('0, '0);
    send_item(31'd1, 31'd3);
    send_item(31'd1, 31'd4);
    send_item(31'd1, 31'd8);
    send_item(31'd10, 31'd5);
    send_item(31'd7, 31'd2);
    send_item(31'd22, 31'd7);
    send_item(31'd1, 31'd7);
    send_item(31'h2aaa_aaaa, 31'h5555_5555);
    send_item(31'h5555_5555, 31'h2aaa_aaaa);
    send_item(31'd5, 31'h4000_0000);
    send_item(TOP, 31'd10);
    send_item(31'd9, 31'd10);
  endtask

  // zero acts as one and anything above the maximum saturates
  task automatic test_digit_settings();
    logic [dld_pkg::CFG_BITS-1:0] settings[7] = '{4'd0, 4'd1, 4'd10, 4'd15, 4'd11,
                                                   4'd2, 4'd9};
    int s;
    stall_max = 3;
    for (s = 0; s < 7; s++) begin
      write_digit_setting(settings[s]);
      send_item(31'd1, 31'd7);
      send_item(31'd22, 31'd7);
      send_item(31'd1, 31'd8);
      send_item(31'h7fff_fffe, 31'h7fff_ffff);
      idle_cycles($urandom_range(0, 3));
    end
  endtask

  task automatic test_pause_until_empty();
    stall_max = 5;
    write_digit_setting(4'd6);
    run_random_items(8, 0);
    wait_results_done();
    run_random_items(8, 0);
  endtask

  task automatic test_random_phases();
    write_digit_setting(4'd10);
    stall_max = 0;
    run_random_items(76, 0);
    write_digit_setting(4'd4);
    stall_max = 3;
    run_random_items(76, 4);
    write_digit_setting(4'd15);
    stall_max = 12;
    run_random_items(76, 10);
    write_digit_setting(4'd1);
    stall_max = 6;
    run_random_items(76, 2);
    write_digit_setting(4'($urandom_range(0, 15)));
    stall_max = 2;
    run_random_items(76, 20);
  endtask

  initial begin
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_directed();
    test_digit_settings();
    test_pause_until_empty();
    test_random_phases();
    @(negedge clk);
    in_valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (expected_results.size() != 0)
      report_mismatch($sformatf("%0d results never arrived", expected_results.size()));
    if (mismatch_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  initial begin
    #4_000_000;
    $display("timeout with %0d results outstanding", expected_results.size());
    $display("Some tests failed");
    $finish;
  end

endmodule
